FILE: rtl/core/rbhr_pkg.sv
// Shared constants, types and width helpers for the radial brush height raise unit.
`default_nettype none

package rbhr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int HEIGHT_W       = 32;
  localparam int INC_FRAC       = 16;
  localparam int INC_W          = INC_FRAC + 1;
  localparam int CENTER_W       = 26;
  localparam int SIZE_W         = 24;
  localparam int SCALE_W        = 5;
  localparam int REM_W          = SIZE_W + INC_FRAC;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 26;
  localparam int OUT_W          = 4 * HEIGHT_W;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(256);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_SIZE     = 2'd2,
    REG_SCALE    = 2'd3
  } cfg_reg_t;

  // Configuration as seen by every lane
  typedef struct packed {
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [SIZE_W-1:0]          size;
    logic [SCALE_W-1:0]         scale;
  } cfg_t;

  // Width of a scaled sample position in fixed point
  function automatic int rbhr_pos_w(input int c, input int f);
    return c + 6 + f;
  endfunction

  // Signed delta width: covers position and centre with margin for the subtract
  function automatic int rbhr_dx_w(input int c, input int f);
    int p;
    p = rbhr_pos_w(c, f);
    return ((p > CENTER_W - 1) ? p : CENTER_W - 1) + 2;
  endfunction

  // Delta magnitude width, clamped at 31 bits
  function automatic int rbhr_mag_w(input int c, input int f);
    int d;
    d = rbhr_dx_w(c, f) - 1;
    return (d > 31) ? 31 : d;
  endfunction

  // Cycles from input acceptance to the output register
  function automatic int rbhr_latency(input int c, input int f);
    return rbhr_mag_w(c, f) + 23;
  endfunction

  // Input bus width rounded up to whole bytes
  function automatic int rbhr_in_w(input int c);
    return ((2 * c + 4 * HEIGHT_W + 7) / 8) * 8;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rbhr_sqrt_cell.sv
// One step of the bitwise integer square root, registered.
`default_nettype none

module rbhr_sqrt_cell import rbhr_pkg::*; #(
  parameter int W       = 56,
  parameter int BIT_POS = 54
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [W-1:0]        v_in,
  input  wire logic [W-1:0]        r_in,
  input  wire logic [HEIGHT_W-1:0] h_in,
  output logic [W-1:0]             v_out,
  output logic [W-1:0]             r_out,
  output logic [HEIGHT_W-1:0]      h_out
);

  logic [W-1:0] bitv;
  logic [W-1:0] trial;
  logic [W-1:0] v_next;
  logic [W-1:0] r_next;

  // Try to set this result bit
  always_comb begin
    bitv  = W'(1) << BIT_POS;
    trial = r_in + bitv;
    if (v_in >= trial) begin
      v_next = v_in - trial;
      r_next = (r_in >> 1) + bitv;
    end else begin
      v_next = v_in;
      r_next = r_in >> 1;
    end
  end

  // Hand to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= v_next;
      r_out <= r_next;
      h_out <= h_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rbhr_div_cell.sv
// One step of the restoring divider for the brush increment, registered.
`default_nettype none

module rbhr_div_cell import rbhr_pkg::*; #(
  parameter int DEN_W = 29,
  parameter int SHIFT = 16
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [DEN_W-1:0]    den_in,
  input  wire logic [REM_W-1:0]    rem_in,
  input  wire logic [INC_W-1:0]    q_in,
  input  wire logic [HEIGHT_W-1:0] h_in,
  output logic [DEN_W-1:0]         den_out,
  output logic [REM_W-1:0]         rem_out,
  output logic [INC_W-1:0]         q_out,
  output logic [HEIGHT_W-1:0]      h_out
);

  localparam int CW = DEN_W + INC_FRAC;

  logic [CW-1:0]    dsh;
  logic [CW-1:0]    remw;
  logic [REM_W-1:0] rem_next;
  logic [INC_W-1:0] q_next;

  // Subtract the shifted divisor when it fits
  always_comb begin
    dsh  = CW'(den_in) << SHIFT;
    remw = CW'(rem_in);
    if (remw >= dsh) begin
      rem_next = REM_W'(remw - dsh);
      q_next   = q_in | (INC_W'(1) << SHIFT);
    end else begin
      rem_next = rem_in;
      q_next   = q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      rem_out <= rem_next;
      q_out   <= q_next;
      h_out   <= h_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rbhr_lane.sv
// One sample lane: delta, squares, root cells, divider cells and saturating add.
`default_nettype none

module rbhr_lane import rbhr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int OFF_X      = 0,
  parameter int OFF_Y      = 0
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire cfg_t                  cfg,
  input  wire logic [COORD_BITS-1:0] texel_x,
  input  wire logic [COORD_BITS-1:0] texel_y,
  input  wire logic [HEIGHT_W-1:0]   height,
  output logic [HEIGHT_W-1:0]        raised
);

  localparam int P_W    = rbhr_pos_w(COORD_BITS, FRAC_BITS);
  localparam int DX_W   = rbhr_dx_w(COORD_BITS, FRAC_BITS);
  localparam int MAG_W  = rbhr_mag_w(COORD_BITS, FRAC_BITS);
  localparam int SUM_W  = 2 * MAG_W + 2;
  localparam int NS     = MAG_W + 1;
  localparam int DIST_W = MAG_W + 1;
  localparam int DEN_W  = ((DIST_W > SIZE_W) ? DIST_W : SIZE_W) + 1;
  localparam int ND     = INC_W;
  localparam int B_W    = COORD_BITS + 6;

  // Sample position and delta to the centre
  logic [B_W-1:0]         px, py;
  logic [P_W-1:0]         pfx, pfy;
  logic signed [DX_W-1:0] dx, dy;
  logic [DX_W-1:0]        ax, ay;
  logic [MAG_W-1:0]       mx_next, my_next;

  always_comb begin
    px  = B_W'({texel_x, 1'b0}) * B_W'(cfg.scale) + B_W'(OFF_X);
    py  = B_W'({texel_y, 1'b0}) * B_W'(cfg.scale) + B_W'(OFF_Y);
    pfx = P_W'(px) << FRAC_BITS;
    pfy = P_W'(py) << FRAC_BITS;
    dx  = $signed(DX_W'(pfx)) - DX_W'(cfg.cx);
    dy  = $signed(DX_W'(pfy)) - DX_W'(cfg.cy);
    ax  = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
    ay  = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);
  end

  // Clamp magnitudes at 2^31 - 1 where the delta can grow that far
  if (DX_W - 1 > 31) begin : g_clamp
    localparam logic [DX_W-1:0] SAT = DX_W'(32'h7FFF_FFFF);
    assign mx_next = (ax > SAT) ? MAG_W'(SAT) : ax[MAG_W-1:0];
    assign my_next = (ay > SAT) ? MAG_W'(SAT) : ay[MAG_W-1:0];
  end else begin : g_plain
    assign mx_next = ax[MAG_W-1:0];
    assign my_next = ay[MAG_W-1:0];
  end

  // Front stages: magnitudes, squares, sum
  logic [MAG_W-1:0]     mx, my;
  logic [2*MAG_W-1:0]   sx, sy;
  logic [SUM_W-1:0]     ssum;
  logic [HEIGHT_W-1:0]  ha, hb, hc;

  always_ff @(posedge clk) begin
    if (en) begin
      mx   <= mx_next;
      my   <= my_next;
      ha   <= height;
      sx   <= mx * mx;
      sy   <= my * my;
      hb   <= ha;
      ssum <= SUM_W'(sx) + SUM_W'(sy);
      hc   <= hb;
    end
  end

  // Square root chain, one result bit per cell
  logic [SUM_W-1:0]    sv [NS+1];
  logic [SUM_W-1:0]    sr [NS+1];
  logic [HEIGHT_W-1:0] sh [NS+1];

  assign sv[0] = ssum;
  assign sr[0] = '0;
  assign sh[0] = hc;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    rbhr_sqrt_cell #(
      .W       (SUM_W),
      .BIT_POS (SUM_W - 2 - 2 * k)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .v_in  (sv[k]),
      .r_in  (sr[k]),
      .h_in  (sh[k]),
      .v_out (sv[k+1]),
      .r_out (sr[k+1]),
      .h_out (sh[k+1])
    );
  end

  // Divisor and dividend setup
  logic [DIST_W-1:0]   radius;
  logic [DEN_W-1:0]    dd0;
  logic [REM_W-1:0]    dr0;
  logic [HEIGHT_W-1:0] dh0;
  logic [DEN_W-1:0]    dd [ND+1];
  logic [REM_W-1:0]    dr [ND+1];
  logic [INC_W-1:0]    dq [ND+1];
  logic [HEIGHT_W-1:0] dh [ND+1];

  assign radius = sr[NS][DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dd0 <= DEN_W'(cfg.size) + DEN_W'(radius);
      dr0 <= {cfg.size, INC_FRAC'(0)};
      dh0 <= sh[NS];
    end
  end
  assign dd[0] = dd0;
  assign dr[0] = dr0;
  assign dh[0] = dh0;
  assign dq[0] = '0;

  // Divider chain, quotient bits from the top down
  for (genvar k = 0; k < ND; k++) begin : g_div
    rbhr_div_cell #(
      .DEN_W (DEN_W),
      .SHIFT (ND - 1 - k)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .den_in  (dd[k]),
      .rem_in  (dr[k]),
      .q_in    (dq[k]),
      .h_in    (dh[k]),
      .den_out (dd[k+1]),
      .rem_out (dr[k+1]),
      .q_out   (dq[k+1]),
      .h_out   (dh[k+1])
    );
  end

  // Add increment and saturate upward
  logic [INC_W-1:0]       inc;
  logic signed [HEIGHT_W:0] hsum;
  logic [HEIGHT_W-1:0]    raised_next;

  always_comb begin
    inc  = (cfg.size == '0) ? '0 : dq[ND];
    hsum = $signed({dh[ND][HEIGHT_W-1], dh[ND]}) + $signed((HEIGHT_W+1)'(inc));
    if (hsum > $signed((HEIGHT_W+1)'(32'h7FFF_FFFF))) begin
      raised_next = 32'h7FFF_FFFF;
    end else begin
      raised_next = hsum[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raised <= raised_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/radial_brush_height_raise_unit.sv
// Top level of the radial brush height raise unit: config, four lanes, valid chain.
//
// Channel  Dir  Handshake           Content
// s_*      in   s_tvalid/s_tready   texel_x, texel_y, height_00/10/01/11
// m_*      out  m_tvalid/m_tready   raised_00/10/01/11
// cfg_*    in   cfg_valid/cfg_ready register index, write data
//
// One item enters per cycle while the output is not stalled; each item passes through
// the front stages, the square root cell chain (one cell per result bit), the divider
// setup register, 17 divider cells and the output register.
// Reset clears the valid chain and loads the register defaults; no clearing pass.
// A stalled output freezes the whole chain and drops s_tready in the same cycle.
`default_nettype none

module radial_brush_height_raise_unit import rbhr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // texel_x, texel_y, height_00, height_10, height_01, height_11, zero pad
  input  wire logic [rbhr_in_w(COORD_BITS)-1:0]   s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // raised_00, raised_10, raised_01, raised_11
  output logic [OUT_W-1:0]                        m_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]               cfg_index,
  input  wire logic [CFG_DATA_W-1:0]              cfg_data
);

  localparam int LAT = rbhr_latency(COORD_BITS, FRAC_BITS);
  localparam int HB  = 2 * COORD_BITS;

  // Configuration registers
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cx    <= '0;
      cfg.cy    <= '0;
      cfg.size  <= SIZE_RESET;
      cfg.scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: cfg.cx    <= $signed(cfg_data);
        REG_CENTER_Y: cfg.cy    <= $signed(cfg_data);
        REG_SIZE:     cfg.size  <= cfg_data[SIZE_W-1:0];
        REG_SCALE:    cfg.scale <= cfg_data[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  // Advance the chain when the output is free or being taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Valid chain alongside the lanes
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  assign m_tvalid = vld[LAT-1];

  // Input fields
  logic [COORD_BITS-1:0] texel_x, texel_y;
  logic [HEIGHT_W-1:0]   height [4];
  logic [HEIGHT_W-1:0]   raised [4];

  assign texel_x = s_tdata[COORD_BITS-1:0];
  assign texel_y = s_tdata[HB-1:COORD_BITS];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign height[k] = s_tdata[HB + HEIGHT_W*k +: HEIGHT_W];

    rbhr_lane #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .OFF_X      (k % 2),
      .OFF_Y      (k / 2)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .cfg     (cfg),
      .texel_x (texel_x),
      .texel_y (texel_y),
      .height  (height[k]),
      .raised  (raised[k])
    );
  end

  assign m_tdata = {raised[3], raised[2], raised[1], raised[0]};

  // Reset leaves no result on the output
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // A frozen chain keeps its valid pattern
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid chain moved during a stall");

  // Hold the result steady while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output changed while stalled");

endmodule

`default_nettype wire
